// File: hdl/smc_key_access_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keyed command port sequencer
// Immediate-style wrappers around concurrent assertions, clocked on the rising
// edge and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SMC_KEY_ACCESS_SEQUENCER_ASSERT_SVH
`define SMC_KEY_ACCESS_SEQUENCER_ASSERT_SVH

`ifndef ASSERT_OFF

// Holds in the same cycle.
`define SMC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Holds in the cycle after.
`define SMC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SMC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define SMC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: hdl/smc_kas_pkg.sv
// ----------------------------------------------------------------------------
// smc_kas_pkg
// Shared constants and types of the keyed command port sequencer.
// ----------------------------------------------------------------------------
package smc_kas_pkg;

  localparam int MAX_PAYLOAD_DEFAULT = 32;

  // Payload buffer geometry.
  localparam int BUF_DEPTH = 32;
  localparam int BUF_AW    = 5;

  // Configuration register indexes and reset values.
  localparam logic CFG_ATTEMPT_LIMIT = 1'b0;
  localparam logic CFG_POLL_LIMIT    = 1'b1;
  localparam logic [2:0] ATTEMPT_LIMIT_RESET = 3'd3;
  localparam logic [9:0] POLL_LIMIT_RESET    = 10'd500;

  // Item kinds.
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  // Command codes.
  localparam logic [7:0] CMD_READ  = 8'h10;
  localparam logic [7:0] CMD_WRITE = 8'h11;
  localparam logic [7:0] CMD_INFO  = 8'h13;

  // Flag bit positions in the command port sample.
  localparam int FLAG_OBF = 0;
  localparam int FLAG_IBF = 1;
  localparam int FLAG_ACC = 2;

  // Outcome codes.
  localparam logic [1:0] OUTCOME_OK     = 2'd0;
  localparam logic [1:0] OUTCOME_FAIL   = 2'd1;
  localparam logic [1:0] OUTCOME_STATUS = 2'd2;

  // Access request from the controller to the payload buffer.
  typedef struct packed {
    logic              we;
    logic [BUF_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic [BUF_AW-1:0] raddr;
  } buf_req_t;

endpackage

// File: hdl/smc_kas_buffer.sv
// ----------------------------------------------------------------------------
// smc_kas_buffer
// Payload buffer: one write port, one registered read port, with a bypass for
// a write that lands on the address being read in the same cycle.
// ----------------------------------------------------------------------------
module smc_kas_buffer (
  input  logic                   clk,
  input  logic                   rst,
  input  smc_kas_pkg::buf_req_t  req,
  output logic [7:0]             rdata
);

  logic [7:0] mem [smc_kas_pkg::BUF_DEPTH];
  logic [7:0] rd_q;
  logic [7:0] fwd_data;
  logic       fwd_hit;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_q     <= mem[req.raddr];
    fwd_data <= req.wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= req.we && (req.waddr == req.raddr);
    end
  end

  // The array read sees the old contents, so a same-address write is bypassed.
  assign rdata = fwd_hit ? fwd_data : rd_q;

endmodule

// File: hdl/smc_kas_ctrl.sv
// ----------------------------------------------------------------------------
// smc_kas_ctrl
// Request sequencer: phase machine, counters, configuration registers and the
// registered result beat.
// ----------------------------------------------------------------------------
module smc_kas_ctrl #(
  parameter int MAX_PAYLOAD = smc_kas_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [9:0]            cfg_data,
  input  logic                  in_accept,
  input  logic [1:0]            kind,
  input  logic [7:0]            command,
  input  logic [31:0]           key_word,
  input  logic [7:0]            length,
  input  logic [4:0]            load_index,
  input  logic [7:0]            load_byte,
  input  logic [7:0]            flags_sample,
  input  logic [7:0]            data_sample,
  input  logic [7:0]            status_sample,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  port_write,
  output logic                  port_is_command,
  output logic [7:0]            port_byte,
  output logic                  read_valid,
  output logic [4:0]            read_index,
  output logic [7:0]            read_byte,
  output logic                  done_res,
  output logic [1:0]            outcome,
  output logic [7:0]            status_byte,
  output logic                  busy_res,
  output smc_kas_pkg::buf_req_t buf_req,
  input  logic [7:0]            buf_rdata
);

  localparam int CntWRaw = $clog2(MAX_PAYLOAD + 1);
  localparam int CntW    = (CntWRaw < smc_kas_pkg::BUF_AW) ? smc_kas_pkg::BUF_AW : CntWRaw;

  typedef enum logic [3:0] {
    PH_IDLE, PH_CMD_IBF, PH_CMD_ACC, PH_KEY_IBF, PH_KEY_ACC,
    PH_LEN_IBF, PH_LEN_ACC, PH_WR_IBF, PH_WR_ACC, PH_RD_OBF
  } phase_t;

  phase_t           phase, phase_next;
  logic [CntW-1:0]  byte_cnt, byte_cnt_next;
  logic [2:0]       attempt_cnt, attempt_cnt_next;
  logic [9:0]       poll_cnt, poll_cnt_next;
  logic [7:0]       saved_command;
  logic [31:0]      saved_key;
  logic [CntW-1:0]  saved_length;
  logic [2:0]       attempt_limit;
  logic [9:0]       poll_limit;

  logic             r_write, r_is_cmd, r_read, r_done;
  logic [7:0]       r_byte, r_rbyte, r_status;
  logic [4:0]       r_rindex;
  logic [1:0]       r_outcome;

  logic [CntW:0]    byte_inc;
  logic             attempt_last, poll_last;
  logic [1:0]       fail_code;
  logic [7:0]       key_byte;
  logic             save_req;

  assign byte_inc     = {1'b0, byte_cnt} + (CntW+1)'(1);
  assign attempt_last = ({1'b0, attempt_cnt} + 4'd1) >= {1'b0, attempt_limit};
  assign poll_last    = ({1'b0, poll_cnt} + 11'd1) >= {1'b0, poll_limit};
  assign fail_code    = (status_sample != 8'd0) ? smc_kas_pkg::OUTCOME_STATUS
                                                : smc_kas_pkg::OUTCOME_FAIL;

  always_comb begin
    case (byte_cnt[1:0])
      2'd0:    key_byte = saved_key[31:24];
      2'd1:    key_byte = saved_key[23:16];
      2'd2:    key_byte = saved_key[15:8];
      default: key_byte = saved_key[7:0];
    endcase
  end

  always_comb begin
    logic do_miss;
    logic do_fail;
    logic do_finish;
    logic [1:0] fin_code;

    do_miss          = 1'b0;
    do_fail          = 1'b0;
    do_finish        = 1'b0;
    fin_code         = smc_kas_pkg::OUTCOME_OK;
    phase_next       = phase;
    byte_cnt_next    = byte_cnt;
    attempt_cnt_next = attempt_cnt;
    poll_cnt_next    = poll_cnt;
    save_req         = 1'b0;
    r_write          = 1'b0;
    r_is_cmd         = 1'b0;
    r_byte           = 8'd0;
    r_read           = 1'b0;
    r_rindex         = 5'd0;
    r_rbyte          = 8'd0;
    r_done           = 1'b0;
    r_outcome        = smc_kas_pkg::OUTCOME_OK;
    r_status         = 8'd0;

    if (in_accept) begin
      if (kind == smc_kas_pkg::KIND_START && phase == PH_IDLE) begin
        save_req         = 1'b1;
        attempt_cnt_next = 3'd0;
        poll_cnt_next    = 10'd0;
        byte_cnt_next    = '0;
        if ({1'b0, length} > 9'(MAX_PAYLOAD)) begin
          do_finish = 1'b1;
          fin_code  = fail_code;
        end else begin
          phase_next = PH_CMD_IBF;
        end
      end else if (kind == smc_kas_pkg::KIND_SAMPLE && phase != PH_IDLE) begin
        case (phase)
          PH_CMD_IBF, PH_KEY_IBF, PH_LEN_IBF, PH_WR_IBF: begin
            if (!flags_sample[smc_kas_pkg::FLAG_IBF]) begin
              r_write       = 1'b1;
              r_is_cmd      = (phase == PH_CMD_IBF);
              poll_cnt_next = 10'd0;
              case (phase)
                PH_CMD_IBF: begin
                  r_byte     = saved_command;
                  phase_next = PH_CMD_ACC;
                end
                PH_KEY_IBF: begin
                  r_byte     = key_byte;
                  phase_next = PH_KEY_ACC;
                end
                PH_LEN_IBF: begin
                  r_byte     = 8'(saved_length);
                  phase_next = PH_LEN_ACC;
                end
                default: begin
                  r_byte     = buf_rdata;
                  phase_next = PH_WR_ACC;
                end
              endcase
            end else begin
              do_miss = 1'b1;
            end
          end
          PH_CMD_ACC, PH_KEY_ACC, PH_LEN_ACC, PH_WR_ACC: begin
            if (flags_sample[smc_kas_pkg::FLAG_ACC]) begin
              poll_cnt_next = 10'd0;
              case (phase)
                PH_CMD_ACC: begin
                  byte_cnt_next = '0;
                  phase_next    = PH_KEY_IBF;
                end
                PH_KEY_ACC: begin
                  if (byte_inc >= (CntW+1)'(4)) begin
                    byte_cnt_next = '0;
                    phase_next    = PH_LEN_IBF;
                  end else begin
                    byte_cnt_next = byte_inc[CntW-1:0];
                    phase_next    = PH_KEY_IBF;
                  end
                end
                PH_LEN_ACC: begin
                  byte_cnt_next = '0;
                  if (saved_command == smc_kas_pkg::CMD_READ ||
                      saved_command == smc_kas_pkg::CMD_INFO) begin
                    if (saved_length == '0) do_finish = 1'b1;
                    else phase_next = PH_RD_OBF;
                  end else if (saved_command == smc_kas_pkg::CMD_WRITE) begin
                    if (saved_length == '0) do_finish = 1'b1;
                    else phase_next = PH_WR_IBF;
                  end else begin
                    do_fail = 1'b1;
                  end
                end
                default: begin
                  byte_cnt_next = byte_inc[CntW-1:0];
                  if (byte_inc >= {1'b0, saved_length}) do_finish = 1'b1;
                  else phase_next = PH_WR_IBF;
                end
              endcase
            end else begin
              do_miss = 1'b1;
            end
          end
          PH_RD_OBF: begin
            if (flags_sample[smc_kas_pkg::FLAG_OBF]) begin
              r_read        = 1'b1;
              r_rindex      = byte_cnt[4:0];
              r_rbyte       = data_sample;
              poll_cnt_next = 10'd0;
              byte_cnt_next = byte_inc[CntW-1:0];
              if (byte_inc >= {1'b0, saved_length}) do_finish = 1'b1;
            end else begin
              do_miss = 1'b1;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end

    if (do_miss) begin
      if (poll_last) do_fail = 1'b1;
      else poll_cnt_next = poll_cnt + 10'd1;
    end
    // A failed attempt either restarts from the command byte or ends the request.
    if (do_fail) begin
      if (attempt_last) begin
        do_finish = 1'b1;
        fin_code  = fail_code;
      end else begin
        attempt_cnt_next = attempt_cnt + 3'd1;
        phase_next       = PH_CMD_IBF;
        byte_cnt_next    = '0;
        poll_cnt_next    = 10'd0;
      end
    end
    if (do_finish) begin
      r_done     = 1'b1;
      r_outcome  = fin_code;
      r_status   = (fin_code == smc_kas_pkg::OUTCOME_STATUS) ? status_sample : 8'd0;
      phase_next = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_cnt      <= '0;
      attempt_cnt   <= 3'd0;
      poll_cnt      <= 10'd0;
      saved_command <= 8'd0;
      saved_key     <= 32'd0;
      saved_length  <= '0;
      attempt_limit <= smc_kas_pkg::ATTEMPT_LIMIT_RESET;
      poll_limit    <= smc_kas_pkg::POLL_LIMIT_RESET;
      out_valid     <= 1'b0;
    end else begin
      phase       <= phase_next;
      byte_cnt    <= byte_cnt_next;
      attempt_cnt <= attempt_cnt_next;
      poll_cnt    <= poll_cnt_next;
      if (save_req) begin
        saved_command <= command;
        saved_key     <= key_word;
        saved_length  <= length[CntW-1:0];
      end
      if (cfg_write) begin
        if (cfg_index == smc_kas_pkg::CFG_ATTEMPT_LIMIT) attempt_limit <= cfg_data[2:0];
        else poll_limit <= cfg_data;
      end
      if (in_accept) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Result beat payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      port_write      <= r_write;
      port_is_command <= r_is_cmd;
      port_byte       <= r_byte;
      read_valid      <= r_read;
      read_index      <= r_rindex;
      read_byte       <= r_rbyte;
      done_res        <= r_done;
      outcome         <= r_outcome;
      status_byte     <= r_status;
      busy_res        <= (phase_next != PH_IDLE);
    end
  end

  // The buffer is read at the counter's next value, so the byte is ready when
  // the next sample arrives.
  always_comb begin
    buf_req.we    = in_accept && (kind == smc_kas_pkg::KIND_LOAD);
    buf_req.waddr = load_index;
    buf_req.wdata = load_byte;
    buf_req.raddr = byte_cnt_next[4:0];
  end

endmodule

// File: hdl/smc_key_access_sequencer.sv
// The result beat of an item is presented in the cycle after the item is accepted.
// One item per cycle unless the output is stalled; the payload buffer's single read port is
// addressed ahead by the byte counter, so a data byte is always ready for the next sample.
// Reset (synchronous, active high) returns the sequencer to idle, clears counters and saved
// request fields and restores attempt_limit 3 and poll_limit 500; the payload buffer keeps
// its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
// smc_key_access_sequencer
// Host-side sequencer for a keyed command port: loads payload bytes, then
// drives command, key, length and payload bytes, or reads data bytes, with flag polling and retries.
// ----------------------------------------------------------------------------
`include "smc_key_access_sequencer_assert.svh"

module smc_key_access_sequencer #(
  parameter int MAX_PAYLOAD = smc_kas_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  command,
  input  logic [31:0] key_word,
  input  logic [7:0]  length,
  input  logic [4:0]  load_index,
  input  logic [7:0]  load_byte,
  input  logic [7:0]  flags_sample,
  input  logic [7:0]  data_sample,
  input  logic [7:0]  status_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        port_write,
  output logic        port_is_command,
  output logic [7:0]  port_byte,
  output logic        read_valid,
  output logic [4:0]  read_index,
  output logic [7:0]  read_byte,
  output logic        done_res,
  output logic [1:0]  outcome,
  output logic [7:0]  status_byte,
  output logic        busy_res
);

  smc_kas_pkg::buf_req_t buf_req;
  logic [7:0]            buf_rdata;
  logic                  in_accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  smc_kas_buffer u_buffer (
    .clk   (clk),
    .rst   (rst),
    .req   (buf_req),
    .rdata (buf_rdata)
  );

  smc_kas_ctrl #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_accept       (in_accept),
    .kind            (kind),
    .command         (command),
    .key_word        (key_word),
    .length          (length),
    .load_index      (load_index),
    .load_byte       (load_byte),
    .flags_sample    (flags_sample),
    .data_sample     (data_sample),
    .status_sample   (status_sample),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .port_write      (port_write),
    .port_is_command (port_is_command),
    .port_byte       (port_byte),
    .read_valid      (read_valid),
    .read_index      (read_index),
    .read_byte       (read_byte),
    .done_res        (done_res),
    .outcome         (outcome),
    .status_byte     (status_byte),
    .busy_res        (busy_res),
    .buf_req         (buf_req),
    .buf_rdata       (buf_rdata)
  );

  `SMC_ASSERT_NOW(a_done_not_busy, clk, rst, out_valid && done_res, !busy_res,
                  "finished request still busy")
  `SMC_ASSERT_NOW(a_one_transfer, clk, rst, out_valid, !(port_write && read_valid),
                  "write and read in one beat")
  `SMC_ASSERT_NOW(a_outcome_only_done, clk, rst, out_valid && !done_res,
                  outcome == smc_kas_pkg::OUTCOME_OK && status_byte == 8'd0,
                  "outcome without completion")
  `SMC_ASSERT_NEXT(a_load_no_result, clk, rst,
                   in_valid && in_ready && kind == smc_kas_pkg::KIND_LOAD,
                   out_valid && !port_write && !read_valid && !done_res,
                   "load beat produced a transfer")

endmodule

// File: verif/smc_key_access_sequencer_tb.sv
// ----------------------------------------------------------------------------
// smc_key_access_sequencer_tb
// Self-checking bench for the keyed command port sequencer. A short table of
// directed beats covers idle samples, reserved kinds, loads, oversize lengths
// and one full zero-length request. Random requests follow under several
// retry and poll limits and three idling mixes. Each input beat is run
// through an internal predictor, and every result beat is compared field by
// field with the oldest expected result, which the table gives for its pinned rows.
// ----------------------------------------------------------------------------
module smc_key_access_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          PAYLOAD_MAX   = smc_kas_pkg::MAX_PAYLOAD_DEFAULT;
  localparam int          RANDOM_ITEMS  = 500;
  localparam int          HOLD_CYCLES   = 60;
  localparam logic [1:0]  KIND_RESERVED = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE, PH_CMD_IBF, PH_CMD_ACC, PH_KEY_IBF, PH_KEY_ACC,
    PH_LEN_IBF, PH_LEN_ACC, PH_WR_IBF, PH_WR_ACC, PH_RD_OBF
  } seq_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  command;
    logic [31:0] key_word;
    logic [7:0]  length;
    logic [4:0]  load_index;
    logic [7:0]  load_byte;
    logic [7:0]  flags;
    logic [7:0]  data;
    logic [7:0]  status;
  } seq_item_t;

  typedef struct packed {
    logic       port_write;
    logic       port_is_command;
    logic [7:0] port_byte;
    logic       read_valid;
    logic [4:0] read_index;
    logic [7:0] read_byte;
    logic       done_res;
    logic [1:0] outcome;
    logic [7:0] status_byte;
    logic       busy_res;
  } seq_result_t;

  typedef struct {
    seq_item_t   it;
    bit          pinned;
    seq_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = smc_kas_pkg::CFG_ATTEMPT_LIMIT;
  logic [9:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = smc_kas_pkg::KIND_LOAD;
  logic [7:0]  command = '0;
  logic [31:0] key_word = '0;
  logic [7:0]  length = '0;
  logic [4:0]  load_index = '0;
  logic [7:0]  load_byte = '0;
  logic [7:0]  flags_sample = '0;
  logic [7:0]  data_sample = '0;
  logic [7:0]  status_sample = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        port_write;
  logic        port_is_command;
  logic [7:0]  port_byte;
  logic        read_valid;
  logic [4:0]  read_index;
  logic [7:0]  read_byte;
  logic        done_res;
  logic [1:0]  outcome;
  logic [7:0]  status_byte;
  logic        busy_res;

  smc_key_access_sequencer dut (.*);

  always #5 clk = ~clk;

  // Predictor state.
  seq_phase_t  seq_phase = PH_IDLE;
  logic [5:0]  byte_cnt = '0;
  logic [2:0]  attempt_cnt = '0;
  logic [9:0]  poll_cnt = '0;
  logic [7:0]  cur_command = '0;
  logic [31:0] cur_key = '0;
  logic [7:0]  cur_length = '0;
  logic [7:0]  payload [PAYLOAD_MAX];
  bit          loaded [PAYLOAD_MAX];
  logic [2:0]  lim_attempts = smc_kas_pkg::ATTEMPT_LIMIT_RESET;
  logic [9:0]  lim_polls = smc_kas_pkg::POLL_LIMIT_RESET;
  seq_result_t step_res;

  seq_result_t pending_results [$];
  stim_row_t   stim_rows [$];
  int          mismatches = 0;
  int          counted_items = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_cnt = 0;

  function automatic void close_request(input logic [1:0] code, input logic [7:0] st);
    step_res.done_res    = 1'b1;
    step_res.outcome     = code;
    step_res.status_byte = (code == smc_kas_pkg::OUTCOME_STATUS) ? st : 8'h00;
    seq_phase = PH_IDLE;
  endfunction

  function automatic void attempt_failed(input logic [7:0] st);
    if (int'(attempt_cnt) + 1 >= int'(lim_attempts)) begin
      close_request((st != 8'h00) ? smc_kas_pkg::OUTCOME_STATUS : smc_kas_pkg::OUTCOME_FAIL,
                    st);
    end else begin
      attempt_cnt = attempt_cnt + 1'b1;
      seq_phase = PH_CMD_IBF;
      byte_cnt = '0;
      poll_cnt = '0;
    end
  endfunction

  function automatic void poll_missed(input logic [7:0] st);
    if (int'(poll_cnt) + 1 >= int'(lim_polls)) begin
      attempt_failed(st);
    end else begin
      poll_cnt = poll_cnt + 1'b1;
    end
  endfunction

  function automatic logic [7:0] outgoing_byte();
    case (seq_phase)
      PH_CMD_IBF: return cur_command;
      PH_KEY_IBF: return cur_key[8 * (3 - byte_cnt[1:0]) +: 8];
      PH_LEN_IBF: return cur_length;
      default:    return payload[byte_cnt[4:0]];
    endcase
  endfunction

  function automatic void byte_accepted(input logic [7:0] st);
    poll_cnt = '0;
    case (seq_phase)
      PH_CMD_ACC: begin
        byte_cnt = '0;
        seq_phase = PH_KEY_IBF;
      end
      PH_KEY_ACC: begin
        byte_cnt = byte_cnt + 1'b1;
        if (byte_cnt >= 4) begin
          seq_phase = PH_LEN_IBF;
          byte_cnt = '0;
        end else begin
          seq_phase = PH_KEY_IBF;
        end
      end
      PH_LEN_ACC: begin
        byte_cnt = '0;
        if (cur_command == smc_kas_pkg::CMD_READ || cur_command == smc_kas_pkg::CMD_INFO ||
            cur_command == smc_kas_pkg::CMD_WRITE) begin
          if (cur_length == 8'd0) begin
            close_request(smc_kas_pkg::OUTCOME_OK, 8'h00);
          end else begin
            seq_phase = (cur_command == smc_kas_pkg::CMD_WRITE) ? PH_WR_IBF : PH_RD_OBF;
          end
        end else begin
          // An unknown command is only rejected once the length byte is through.
          attempt_failed(st);
        end
      end
      default: begin
        byte_cnt = byte_cnt + 1'b1;
        if (byte_cnt >= cur_length) begin
          close_request(smc_kas_pkg::OUTCOME_OK, 8'h00);
        end else begin
          seq_phase = PH_WR_IBF;
        end
      end
    endcase
  endfunction

  function automatic seq_result_t sequencer_step(input seq_item_t it);
    step_res = '0;
    case (it.kind)
      smc_kas_pkg::KIND_LOAD: begin
        payload[it.load_index] = it.load_byte;
        loaded[it.load_index] = 1'b1;
      end
      smc_kas_pkg::KIND_START: begin
        if (seq_phase == PH_IDLE) begin
          cur_command = it.command;
          cur_key = it.key_word;
          cur_length = it.length;
          attempt_cnt = '0;
          poll_cnt = '0;
          byte_cnt = '0;
          if (int'(it.length) > PAYLOAD_MAX) begin
            close_request((it.status != 8'h00) ? smc_kas_pkg::OUTCOME_STATUS
                                               : smc_kas_pkg::OUTCOME_FAIL, it.status);
          end else begin
            seq_phase = PH_CMD_IBF;
          end
        end
      end
      smc_kas_pkg::KIND_SAMPLE: begin
        case (seq_phase)
          PH_IDLE: ;
          PH_CMD_IBF, PH_KEY_IBF, PH_LEN_IBF, PH_WR_IBF: begin
            if (!it.flags[smc_kas_pkg::FLAG_IBF]) begin
              step_res.port_write = 1'b1;
              step_res.port_is_command = (seq_phase == PH_CMD_IBF);
              step_res.port_byte = outgoing_byte();
              seq_phase = seq_phase_t'(seq_phase + 1);
              poll_cnt = '0;
            end else begin
              poll_missed(it.status);
            end
          end
          PH_CMD_ACC, PH_KEY_ACC, PH_LEN_ACC, PH_WR_ACC: begin
            if (it.flags[smc_kas_pkg::FLAG_ACC]) begin
              byte_accepted(it.status);
            end else begin
              poll_missed(it.status);
            end
          end
          PH_RD_OBF: begin
            if (it.flags[smc_kas_pkg::FLAG_OBF]) begin
              step_res.read_valid = 1'b1;
              step_res.read_index = byte_cnt[4:0];
              step_res.read_byte = it.data;
              poll_cnt = '0;
              byte_cnt = byte_cnt + 1'b1;
              if (byte_cnt >= cur_length) begin
                close_request(smc_kas_pkg::OUTCOME_OK, 8'h00);
              end
            end else begin
              poll_missed(it.status);
            end
          end
          default: seq_phase = PH_IDLE;
        endcase
      end
      default: ;
    endcase
    step_res.busy_res = (seq_phase != PH_IDLE);
    return step_res;
  endfunction

  function automatic seq_item_t random_item();
    seq_item_t it;
    it.kind = 2'($urandom_range(3));
    it.command = 8'($urandom);
    it.key_word = $urandom;
    it.length = 8'($urandom);
    it.load_index = 5'($urandom);
    it.load_byte = 8'($urandom);
    it.flags = 8'($urandom);
    it.data = 8'($urandom);
    it.status = 8'($urandom);
    if ($urandom_range(3) == 0) begin
      it.status = 8'h00;
    end
    return it;
  endfunction

  // A flag sample that moves the current wait on with the given odds,
  // and otherwise misses it.
  function automatic seq_item_t flag_poll(input int good_pct);
    seq_item_t it;
    bit hit;
    it = random_item();
    it.kind = smc_kas_pkg::KIND_SAMPLE;
    hit = ($urandom_range(99) < good_pct);
    case (seq_phase)
      PH_CMD_IBF, PH_KEY_IBF, PH_LEN_IBF, PH_WR_IBF: it.flags[smc_kas_pkg::FLAG_IBF] = !hit;
      PH_CMD_ACC, PH_KEY_ACC, PH_LEN_ACC, PH_WR_ACC: it.flags[smc_kas_pkg::FLAG_ACC] = hit;
      PH_RD_OBF: it.flags[smc_kas_pkg::FLAG_OBF] = hit;
      default: ;
    endcase
    return it;
  endfunction

  function automatic void add_row(input logic [1:0] k, input logic [7:0] cmd,
                                  input logic [31:0] key, input logic [7:0] len,
                                  input logic [4:0] idx, input logic [7:0] lbyte,
                                  input logic [7:0] flags, input logic [7:0] st,
                                  input bit pinned, input logic done,
                                  input logic [1:0] outc, input logic [7:0] stb);
    stim_row_t row;
    row.it = '{kind: k, command: cmd, key_word: key, length: len, load_index: idx,
               load_byte: lbyte, flags: flags, data: 8'h00, status: st};
    row.pinned = pinned;
    row.res = '0;
    row.res.done_res = done;
    row.res.outcome = outc;
    row.res.status_byte = stb;
    stim_rows.push_back(row);
  endfunction

  task automatic push_item(input seq_item_t it, input bit pinned, input seq_result_t pinned_res);
    seq_result_t predicted;
    bit ignored;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= it.kind;
    command       <= it.command;
    key_word      <= it.key_word;
    length        <= it.length;
    load_index    <= it.load_index;
    load_byte     <= it.load_byte;
    flags_sample  <= it.flags;
    data_sample   <= it.data;
    status_sample <= it.status;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ignored = (it.kind == KIND_RESERVED) ||
              (it.kind == smc_kas_pkg::KIND_SAMPLE && seq_phase == PH_IDLE) ||
              (it.kind == smc_kas_pkg::KIND_START && seq_phase != PH_IDLE);
    if (!ignored) begin
      counted_items++;
    end
    predicted = sequencer_step(it);
    pending_results.push_back(pinned ? pinned_res : predicted);
  endtask

  task automatic set_limits(input logic [2:0] attempts, input logic [9:0] polls);
    logic [6:0] pad;
    pad = 7'($urandom);
    cfg_valid <= 1'b1;
    cfg_index <= smc_kas_pkg::CFG_ATTEMPT_LIMIT;
    cfg_data  <= {pad, attempts};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    lim_attempts = attempts;
    cfg_index <= smc_kas_pkg::CFG_POLL_LIMIT;
    cfg_data  <= polls;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    lim_polls = polls;
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One random request, preceded by whatever loads a write needs; stray beats may come before and during it.
  task automatic run_request(input int good_pct);
    seq_item_t it;
    seq_item_t extra;
    int k;
    if ($urandom_range(9) == 0) begin
      extra = random_item();
      extra.kind = $urandom_range(1) ? smc_kas_pkg::KIND_SAMPLE : KIND_RESERVED;
      push_item(extra, 1'b0, '0);
    end
    it = random_item();
    it.kind = smc_kas_pkg::KIND_START;
    case ($urandom_range(9))
      0, 1, 2: it.command = smc_kas_pkg::CMD_READ;
      3, 4, 5: it.command = smc_kas_pkg::CMD_WRITE;
      6, 7:    it.command = smc_kas_pkg::CMD_INFO;
      default: ;
    endcase
    case ($urandom_range(19))
      0:       it.length = 8'($urandom_range(255, PAYLOAD_MAX + 1));
      1:       it.length = 8'd0;
      2:       it.length = 8'(PAYLOAD_MAX);
      3, 4:    it.length = 8'($urandom_range(PAYLOAD_MAX, 9));
      default: it.length = 8'($urandom_range(8, 1));
    endcase
    if (it.command == smc_kas_pkg::CMD_WRITE && int'(it.length) <= PAYLOAD_MAX) begin
      for (k = 0; k < int'(it.length); k++) begin
        if (!loaded[k]) begin
          extra = random_item();
          extra.kind = smc_kas_pkg::KIND_LOAD;
          extra.load_index = 5'(k);
          push_item(extra, 1'b0, '0);
        end
      end
    end
    push_item(it, 1'b0, '0);
    while (seq_phase != PH_IDLE) begin
      if ($urandom_range(19) == 0) begin
        extra = random_item();
        case ($urandom_range(2))
          0:       extra.kind = smc_kas_pkg::KIND_LOAD;
          1:       extra.kind = smc_kas_pkg::KIND_START;
          default: extra.kind = KIND_RESERVED;
        endcase
        push_item(extra, 1'b0, '0);
      end else begin
        push_item(flag_poll(good_pct), 1'b0, '0);
      end
    end
  endtask

  // Receiver: random back-pressure, plus one long hold when the driver asks.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt = hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_cnt = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    seq_result_t got;
    seq_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = {port_write, port_is_command, port_byte, read_valid, read_index, read_byte,
             done_res, outcome, status_byte, busy_res};
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, got %0h", $time, got);
      end else begin
        want = pending_results.pop_front();
        check_field("port_write", 8'(want.port_write), 8'(got.port_write));
        check_field("port_is_command", 8'(want.port_is_command), 8'(got.port_is_command));
        check_field("port_byte", want.port_byte, got.port_byte);
        check_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
        check_field("read_index", 8'(want.read_index), 8'(got.read_index));
        check_field("read_byte", want.read_byte, got.read_byte);
        check_field("done_res", 8'(want.done_res), 8'(got.done_res));
        check_field("outcome", 8'(want.outcome), 8'(got.outcome));
        check_field("status_byte", want.status_byte, got.status_byte);
        check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int p;
    int base;
    int attempt_set [7];
    int poll_set [7];
    attempt_set = '{3, 1, 7, 0, 2, 7, 5};
    poll_set    = '{500, 1, 2, 0, 3, 1023, 4};

    // Idle beats, loads at both ends of the buffer and oversize lengths first,
    // then one complete zero-length info request with a miss and a busy start.
    add_row(smc_kas_pkg::KIND_SAMPLE, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 5'd31, 8'hFF, 8'hFF, 8'hFF,
            1'b1, 1'b0, smc_kas_pkg::OUTCOME_OK, 8'h00);
    add_row(KIND_RESERVED, 8'h00, 32'h0, 8'h00, 5'd0, 8'h00, 8'h00, 8'h00,
            1'b1, 1'b0, smc_kas_pkg::OUTCOME_OK, 8'h00);
    add_row(smc_kas_pkg::KIND_LOAD, 8'h00, 32'h0, 8'h00, 5'd0, 8'hFF, 8'h00, 8'h00,
            1'b1, 1'b0, smc_kas_pkg::OUTCOME_OK, 8'h00);
    add_row(smc_kas_pkg::KIND_LOAD, 8'h00, 32'h0, 8'h00, 5'd31, 8'h00, 8'h00, 8'h00,
            1'b1, 1'b0, smc_kas_pkg::OUTCOME_OK, 8'h00);
    add_row(smc_kas_pkg::KIND_LOAD, 8'h00, 32'h0, 8'h00, 5'd1, 8'h5A, 8'h00, 8'h00,
            1'b1, 1'b0, smc_kas_pkg::OUTCOME_OK, 8'h00);
    add_row(smc_kas_pkg::KIND_START, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 5'd0, 8'h00, 8'h00, 8'h00,
            1'b1, 1'b1, smc_kas_pkg::OUTCOME_FAIL, 8'h00);
    add_row(smc_kas_pkg::KIND_START, smc_kas_pkg::CMD_WRITE, 32'h0, 8'd33, 5'd0, 8'h00,
            8'h00, 8'h1E, 1'b1, 1'b1, smc_kas_pkg::OUTCOME_STATUS, 8'h1E);
    add_row(smc_kas_pkg::KIND_START, smc_kas_pkg::CMD_INFO, 32'h0123_4567, 8'd0, 5'd0, 8'h00,
            8'h00, 8'h00, 1'b0, 1'b0, smc_kas_pkg::OUTCOME_OK, 8'h00);
    add_row(smc_kas_pkg::KIND_SAMPLE, 8'h00, 32'h0, 8'h00, 5'd0, 8'h00, 8'hFF, 8'h33,
            1'b0, 1'b0, smc_kas_pkg::OUTCOME_OK, 8'h00);
    add_row(smc_kas_pkg::KIND_SAMPLE, 8'h00, 32'h0, 8'h00, 5'd0, 8'h00, 8'hFD, 8'h00,
            1'b0, 1'b0, smc_kas_pkg::OUTCOME_OK, 8'h00);
    add_row(smc_kas_pkg::KIND_START, smc_kas_pkg::CMD_READ, 32'hDEAD_BEEF, 8'd5, 5'd0, 8'h00,
            8'h00, 8'h00, 1'b0, 1'b0, smc_kas_pkg::OUTCOME_OK, 8'h00);
    add_row(smc_kas_pkg::KIND_SAMPLE, 8'h00, 32'h0, 8'h00, 5'd0, 8'h00, 8'h04, 8'h00,
            1'b0, 1'b0, smc_kas_pkg::OUTCOME_OK, 8'h00);
    add_row(smc_kas_pkg::KIND_SAMPLE, 8'h00, 32'h0, 8'h00, 5'd0, 8'h00, 8'h00, 8'h00,
            1'b0, 1'b0, smc_kas_pkg::OUTCOME_OK, 8'h00);
    add_row(smc_kas_pkg::KIND_SAMPLE, 8'h00, 32'h0, 8'h00, 5'd0, 8'h00, 8'hFF, 8'h00,
            1'b0, 1'b0, smc_kas_pkg::OUTCOME_OK, 8'h00);
    add_row(smc_kas_pkg::KIND_SAMPLE, 8'h00, 32'h0, 8'h00, 5'd0, 8'h00, 8'hF9, 8'h00,
            1'b0, 1'b0, smc_kas_pkg::OUTCOME_OK, 8'h00);
    add_row(smc_kas_pkg::KIND_SAMPLE, 8'h00, 32'h0, 8'h00, 5'd0, 8'h00, 8'h04, 8'h00,
            1'b0, 1'b0, smc_kas_pkg::OUTCOME_OK, 8'h00);
    add_row(smc_kas_pkg::KIND_SAMPLE, 8'h00, 32'h0, 8'h00, 5'd0, 8'h00, 8'h01, 8'h00,
            1'b0, 1'b0, smc_kas_pkg::OUTCOME_OK, 8'h00);
    add_row(smc_kas_pkg::KIND_SAMPLE, 8'h00, 32'h0, 8'h00, 5'd0, 8'h00, 8'h0C, 8'h00,
            1'b0, 1'b0, smc_kas_pkg::OUTCOME_OK, 8'h00);
    add_row(smc_kas_pkg::KIND_SAMPLE, 8'h00, 32'h0, 8'h00, 5'd0, 8'h00, 8'h00, 8'h00,
            1'b0, 1'b0, smc_kas_pkg::OUTCOME_OK, 8'h00);
    add_row(smc_kas_pkg::KIND_SAMPLE, 8'h00, 32'h0, 8'h00, 5'd0, 8'h00, 8'h04, 8'h00,
            1'b0, 1'b0, smc_kas_pkg::OUTCOME_OK, 8'h00);
    add_row(smc_kas_pkg::KIND_SAMPLE, 8'h00, 32'h0, 8'h00, 5'd0, 8'h00, 8'hFD, 8'h00,
            1'b0, 1'b0, smc_kas_pkg::OUTCOME_OK, 8'h00);
    add_row(smc_kas_pkg::KIND_SAMPLE, 8'h00, 32'h0, 8'h00, 5'd0, 8'h00, 8'h04, 8'h00,
            1'b0, 1'b0, smc_kas_pkg::OUTCOME_OK, 8'h00);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 8;
    recv_idle_pct = 79;
    foreach (stim_rows[i]) begin
      push_item(stim_rows[i].it, stim_rows[i].pinned, stim_rows[i].res);
    end
    settle();

    base = counted_items;
    for (p = 0; p < 7; p++) begin
      if (p < 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 79;
      end else if (p < 5) begin
        send_idle_pct = 79;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_limits(3'(attempt_set[p]), 10'(poll_set[p]));
      if (p == 1) begin
        hold_req++;
      end
      while (counted_items < base + (p + 1) * RANDOM_ITEMS / 7) begin
        run_request((poll_set[p] >= 500) ? 92 : 70);
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/smc_kas_pkg.sv
hdl/smc_kas_buffer.sv
hdl/smc_kas_ctrl.sv
hdl/smc_key_access_sequencer.sv
verif/smc_key_access_sequencer_tb.sv
